### rtl/pwg_pkg.sv
`default_nettype none
package pwg_pkg;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_STEP  = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_SOLID = 3'd5;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_DAMP   = 3'd4;

    localparam logic [5:0]  SIZE_RST = 6'd32;
    localparam logic [17:0] GAIN_RST = 18'd21845;
    localparam logic [15:0] DAMP_RST = 16'd655;
    localparam logic [10:0] INTENSITY_MUL = 11'd1275;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_ADD   = 8'b0000_0100,
        S_SET   = 8'b0000_1000,
        S_STEP  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_SOLID = 8'b0100_0000,
        S_NOP   = 8'b1000_0000
    } t_state;

    function automatic logic [5:0] clamp_coord(input logic [5:0] v, input logic [5:0] lo,
                                               input logic [5:0] hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        if (v > 41'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -41'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/pressure_wave_grid_3d.sv
// channel  | strobe        | words
// -------- | ------------- | ------------------------------------------------
// command  | start / busy  | i_mode, i_cell_x, i_cell_y, i_cell_z, i_value
// result   | o_strobe      | o_cell_value, o_intensity, o_done_res
// config   | i_cfg_we      | i_cfg_index, i_cfg_data
//
// add and read access one cell, set writes the centre and its six neighbours, solid one column
// step handles one interior cell at a time: six neighbour reads on the single
// read port of the current grid memory, two multiplies and a write back
// clear sweeps both memories, one address a cycle, over all MAX_X*MAX_Y*MAX_Z addresses
// after reset the same sweep runs with busy high and no result word
// the result word is shown for one cycle; the receiver cannot stall it
`default_nettype none
module pressure_wave_grid_3d #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_mode,
    input  wire logic [4:0]         i_cell_x,
    input  wire logic [4:0]         i_cell_y,
    input  wire logic [4:0]         i_cell_z,
    input  wire logic signed [31:0] i_value,
    output logic                    o_strobe,
    output logic signed [31:0]      o_cell_value,
    output logic [7:0]              o_intensity,
    output logic                    o_done_res,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [17:0]        i_cfg_data
);

    localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
    localparam int AW = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    pwg_pkg::t_state r_state, n_state;
    logic [3:0]  r_ph, n_ph;
    logic [5:0]  r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [31:0] r_val, n_val;
    logic [2:0]  r_mode, n_mode;
    logic [AW-1:0] r_cnt, n_cnt;
    logic        r_side, n_side;
    logic signed [34:0] r_acc, n_acc;
    logic signed [31:0] r_nxtc, n_nxtc;
    logic signed [53:0] r_prod1, n_prod1;
    logic signed [38:0] r_t, n_t;
    logic signed [56:0] r_prod2, n_prod2;
    logic        r_strobe, n_strobe;
    logic signed [31:0] r_cell_value, n_cell_value;
    logic [7:0]  r_intensity, n_intensity;
    logic        r_done, n_done;
    logic [5:0]  r_size_x, r_size_y, r_size_z;
    logic [17:0] r_gain;
    logic [15:0] r_damp;

    logic [5:0]  sx, sy, sz;
    logic [2:0]  dir;
    logic [5:0]  nbx, nby, nbz;
    logic [AW-1:0] center_addr, nb_addr;
    logic        clr;
    logic        cur_we, nxt_we;
    logic [AW-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
    logic [31:0] cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
    logic        a_we, b_we;
    logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
    logic [31:0] a_wdata, b_wdata, a_rdata, b_rdata;
    logic signed [42:0] inten_prod;
    logic [25:0] inten_n;
    logic signed [32:0] add_sum;
    logic [16:0] keep;
    logic        step_last;

    function automatic logic [5:0] eff_size(input logic [5:0] s, input int mx);
        if (s < 6'd8) begin
            return 6'd8;
        end else if (int'(s) > mx) begin
            return 6'(mx);
        end
        return s;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y,
                                                input logic [5:0] z);
        return AW'(x) + AW'(MAX_X) * AW'(y) + AW'(MAX_X * MAX_Y) * AW'(z);
    endfunction

    assign sx = eff_size(r_size_x, MAX_X);
    assign sy = eff_size(r_size_y, MAX_Y);
    assign sz = eff_size(r_size_z, MAX_Z);
    assign keep = 17'd65536 - 17'(r_damp);
    assign busy = (r_state != pwg_pkg::S_IDLE);

    assign dir = (r_state == pwg_pkg::S_SET) ? 3'(r_ph - 4'd1) : r_ph[2:0];
    always_comb begin
        nbx = r_x;
        nby = r_y;
        nbz = r_z;
        case (dir)
            3'd0: nbx = r_x - 6'd1;
            3'd1: nbx = r_x + 6'd1;
            3'd2: nby = r_y - 6'd1;
            3'd3: nby = r_y + 6'd1;
            3'd4: nbz = r_z - 6'd1;
            3'd5: nbz = r_z + 6'd1;
            default: nbx = r_x;
        endcase
    end
    assign center_addr = cell_addr(r_x, r_y, r_z);
    assign nb_addr = cell_addr(nbx, nby, nbz);

    assign add_sum = 33'(signed'(cur_rdata)) + 33'(r_val);
    assign inten_prod = 43'(signed'(cur_rdata)) * signed'({32'd0, pwg_pkg::INTENSITY_MUL});
    assign inten_n = inten_prod[42:17];
    assign step_last = (r_x == sx - 6'd2) && (r_y == sy - 6'd2) && (r_z == sz - 6'd2);

    always_comb begin
        n_state = r_state;
        n_ph = r_ph;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_val = r_val;
        n_mode = r_mode;
        n_cnt = r_cnt;
        n_side = r_side;
        n_acc = r_acc;
        n_nxtc = r_nxtc;
        n_prod1 = r_prod1;
        n_t = r_t;
        n_prod2 = r_prod2;
        n_strobe = 1'b0;
        n_cell_value = '0;
        n_intensity = '0;
        n_done = 1'b0;
        clr = 1'b0;
        cur_we = 1'b0;
        cur_waddr = center_addr;
        cur_wdata = '0;
        cur_raddr = center_addr;
        nxt_we = 1'b0;
        nxt_waddr = center_addr;
        nxt_wdata = '0;
        nxt_raddr = center_addr;
        case (r_state)
            pwg_pkg::S_IDLE: begin
                if (start) begin
                    n_mode = i_mode;
                    n_val = i_value;
                    n_ph = '0;
                    n_cnt = '0;
                    n_x = {1'b0, i_cell_x};
                    n_y = {1'b0, i_cell_y};
                    n_z = {1'b0, i_cell_z};
                    case (i_mode)
                        pwg_pkg::MODE_ADD: begin
                            n_state = pwg_pkg::S_ADD;
                            n_x = pwg_pkg::clamp_coord({1'b0, i_cell_x}, 6'd2, sx - 6'd2);
                            n_y = pwg_pkg::clamp_coord({1'b0, i_cell_y}, 6'd2, sy - 6'd2);
                            n_z = pwg_pkg::clamp_coord({1'b0, i_cell_z}, 6'd2, sz - 6'd2);
                        end
                        pwg_pkg::MODE_SET: begin
                            n_state = pwg_pkg::S_SET;
                            n_x = pwg_pkg::clamp_coord({1'b0, i_cell_x}, 6'd3, sx - 6'd3);
                            n_y = pwg_pkg::clamp_coord({1'b0, i_cell_y}, 6'd3, sy - 6'd3);
                            n_z = pwg_pkg::clamp_coord({1'b0, i_cell_z}, 6'd3, sz - 6'd3);
                        end
                        pwg_pkg::MODE_STEP: begin
                            n_state = pwg_pkg::S_STEP;
                            n_x = 6'd1;
                            n_y = 6'd1;
                            n_z = 6'd1;
                        end
                        pwg_pkg::MODE_CLEAR: begin
                            n_state = pwg_pkg::S_CLEAR;
                        end
                        pwg_pkg::MODE_READ: begin
                            n_state = pwg_pkg::S_READ;
                            n_x = pwg_pkg::clamp_coord({1'b0, i_cell_x}, 6'd0, sx - 6'd1);
                            n_y = pwg_pkg::clamp_coord({1'b0, i_cell_y}, 6'd0, sy - 6'd1);
                            n_z = pwg_pkg::clamp_coord({1'b0, i_cell_z}, 6'd0, sz - 6'd1);
                        end
                        pwg_pkg::MODE_SOLID: begin
                            n_z = 6'd1;
                            if (i_cell_x >= 5'd1 && {1'b0, i_cell_x} + 6'd2 <= sx &&
                                i_cell_y >= 5'd1 && {1'b0, i_cell_y} + 6'd2 <= sy) begin
                                n_state = pwg_pkg::S_SOLID;
                            end else begin
                                n_state = pwg_pkg::S_NOP;
                            end
                        end
                        default: begin
                            n_state = pwg_pkg::S_NOP;
                        end
                    endcase
                end
            end
            pwg_pkg::S_CLEAR: begin
                clr = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state = pwg_pkg::S_IDLE;
                    n_cnt = '0;
                    if (r_mode == pwg_pkg::MODE_CLEAR) begin
                        n_strobe = 1'b1;
                        n_done = 1'b1;
                    end
                end
            end
            pwg_pkg::S_ADD: begin
                n_ph = r_ph + 4'd1;
                if (r_ph == 4'd1) begin
                    cur_we = 1'b1;
                    cur_wdata = pwg_pkg::sat32(41'(add_sum));
                    n_state = pwg_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    n_done = 1'b1;
                end
            end
            pwg_pkg::S_READ: begin
                n_ph = r_ph + 4'd1;
                if (r_ph == 4'd1) begin
                    n_state = pwg_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    n_done = 1'b1;
                    n_cell_value = cur_rdata;
                    if (signed'(cur_rdata) > 32'sd0) begin
                        n_intensity = (inten_n > 26'd255) ? 8'd255 : inten_n[7:0];
                    end
                end
            end
            pwg_pkg::S_SET: begin
                n_ph = r_ph + 4'd1;
                cur_we = 1'b1;
                if (r_ph == 4'd0) begin
                    cur_wdata = r_val;
                end else begin
                    cur_waddr = nb_addr;
                    cur_wdata = 32'(r_val >>> 1);
                end
                if (r_ph == 4'd6) begin
                    n_state = pwg_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    n_done = 1'b1;
                end
            end
            pwg_pkg::S_SOLID: begin
                cur_we = 1'b1;
                n_z = r_z + 6'd1;
                if (r_z == sz - 6'd2) begin
                    n_state = pwg_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    n_done = 1'b1;
                end
            end
            pwg_pkg::S_STEP: begin
                n_ph = r_ph + 4'd1;
                cur_raddr = nb_addr;
                if (r_ph == 4'd1) begin
                    n_acc = 35'(signed'(cur_rdata));
                    n_nxtc = nxt_rdata;
                end else if (r_ph >= 4'd2 && r_ph <= 4'd6) begin
                    n_acc = r_acc + 35'(signed'(cur_rdata));
                end
                if (r_ph == 4'd7) begin
                    n_prod1 = 54'(r_acc) * 54'(signed'({1'b0, r_gain}));
                end
                if (r_ph == 4'd8) begin
                    n_t = 39'(signed'(r_prod1[53:16])) - 39'(r_nxtc);
                end
                if (r_ph == 4'd9) begin
                    n_prod2 = 57'(r_t) * 57'(signed'({1'b0, keep}));
                end
                if (r_ph == 4'd10) begin
                    nxt_we = 1'b1;
                    nxt_wdata = pwg_pkg::sat32(r_prod2[56:16]);
                    n_ph = '0;
                    if (step_last) begin
                        n_state = pwg_pkg::S_IDLE;
                        n_side = ~r_side;
                        n_strobe = 1'b1;
                        n_done = 1'b1;
                    end else if (r_x == sx - 6'd2) begin
                        n_x = 6'd1;
                        if (r_y == sy - 6'd2) begin
                            n_y = 6'd1;
                            n_z = r_z + 6'd1;
                        end else begin
                            n_y = r_y + 6'd1;
                        end
                    end else begin
                        n_x = r_x + 6'd1;
                    end
                end
            end
            pwg_pkg::S_NOP: begin
                n_state = pwg_pkg::S_IDLE;
                n_strobe = 1'b1;
                n_done = (r_mode == pwg_pkg::MODE_SOLID);
            end
            default: begin
                n_state = pwg_pkg::S_IDLE;
            end
        endcase
    end

    assign a_we = clr | (r_side ? nxt_we : cur_we);
    assign b_we = clr | (r_side ? cur_we : nxt_we);
    assign a_waddr = clr ? r_cnt : (r_side ? nxt_waddr : cur_waddr);
    assign b_waddr = clr ? r_cnt : (r_side ? cur_waddr : nxt_waddr);
    assign a_wdata = clr ? '0 : (r_side ? nxt_wdata : cur_wdata);
    assign b_wdata = clr ? '0 : (r_side ? cur_wdata : nxt_wdata);
    assign a_raddr = r_side ? nxt_raddr : cur_raddr;
    assign b_raddr = r_side ? cur_raddr : nxt_raddr;
    assign cur_rdata = r_side ? b_rdata : a_rdata;
    assign nxt_rdata = r_side ? a_rdata : b_rdata;

    pwg_ram #(.AW(AW), .DEPTH(CELLS)) u_grid_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    pwg_ram #(.AW(AW), .DEPTH(CELLS)) u_grid_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwg_pkg::S_CLEAR;
            r_ph <= '0;
            r_mode <= pwg_pkg::MODE_ADD;
            r_cnt <= '0;
            r_side <= 1'b0;
            r_strobe <= 1'b0;
            r_cell_value <= '0;
            r_intensity <= '0;
            r_done <= 1'b0;
            r_size_x <= pwg_pkg::SIZE_RST;
            r_size_y <= pwg_pkg::SIZE_RST;
            r_size_z <= pwg_pkg::SIZE_RST;
            r_gain <= pwg_pkg::GAIN_RST;
            r_damp <= pwg_pkg::DAMP_RST;
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            r_mode <= n_mode;
            r_cnt <= n_cnt;
            r_side <= n_side;
            r_strobe <= n_strobe;
            r_cell_value <= n_cell_value;
            r_intensity <= n_intensity;
            r_done <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pwg_pkg::REG_SIZE_X: r_size_x <= i_cfg_data[5:0];
                    pwg_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data[5:0];
                    pwg_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data[5:0];
                    pwg_pkg::REG_GAIN:   r_gain <= i_cfg_data;
                    pwg_pkg::REG_DAMP:   r_damp <= i_cfg_data[15:0];
                    default: r_damp <= r_damp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_val <= n_val;
        r_acc <= n_acc;
        r_nxtc <= n_nxtc;
        r_prod1 <= n_prod1;
        r_t <= n_t;
        r_prod2 <= n_prod2;
    end

    assign o_strobe = r_strobe;
    assign o_cell_value = r_cell_value;
    assign o_intensity = r_intensity;
    assign o_done_res = r_done;

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a running operation");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_quiet_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> (o_done_res == 1'b0 && o_cell_value == 32'sd0 && o_intensity == 8'd0))
        else $error("result ports active without strobe");

    a_intensity_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_intensity != 8'd0 |-> o_cell_value > 32'sd0)
        else $error("intensity set for a non-positive cell");

    a_side_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side != $past(r_side) |-> o_strobe)
        else $error("grid swap outside the end of a step");

endmodule
`default_nettype wire

### rtl/pwg_ram.sv
`default_nettype none
module pwg_ram #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
